>>> hw/rtl/acip_pkg.sv
package acip_pkg;

  localparam int unsigned ValueBits = 64;
  localparam int unsigned PosBits   = 8;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChFive  = 8'h35;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  // Parse phases, one-hot.
  typedef enum logic [12:0] {
    PH_LEAD   = 13'b0000000000001,
    PH_SIGN   = 13'b0000000000010,
    PH_ZERO   = 13'b0000000000100,
    PH_PREFIX = 13'b0000000001000,
    PH_DIGIT  = 13'b0000000010000,
    PH_DOT    = 13'b0000000100000,
    PH_FRAC1  = 13'b0000001000000,
    PH_FRAC   = 13'b0000010000000,
    PH_CHECK  = 13'b0000100000000,
    PH_TAIL   = 13'b0001000000000,
    PH_END    = 13'b0010000000000,
    PH_HOLD   = 13'b0100000000000,
    PH_ERR    = 13'b1000000000000
  } acip_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_DIGITS = 3'd1,
    ERR_ILLEGAL   = 3'd2,
    ERR_MINUS     = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } acip_err_e;

  typedef enum logic [2:0] {
    REG_HEX_BASE       = 3'd0,
    REG_ALLOW_PREFIX   = 3'd1,
    REG_UNSIGNED_ONLY  = 3'd2,
    REG_KEEP_LEAD      = 3'd3,
    REG_KEEP_TRAIL     = 3'd4,
    REG_ANY_TAIL       = 3'd5,
    REG_REQUIRE_DIGITS = 3'd6,
    REG_DECIMAL_ROUND  = 3'd7
  } acip_reg_e;

  typedef struct packed {
    logic hex_base;
    logic allow_hex_prefix;
    logic unsigned_only;
    logic keep_leading_spaces;
    logic keep_trailing_spaces;
    logic allow_any_tail;
    logic require_digits;
    logic allow_decimal_round;
  } acip_cfg_t;

  typedef struct packed {
    acip_phase_e            phase;
    logic [ValueBits-1:0]   acc;
    logic                   digit_seen;
    logic                   negative;
    logic                   base16;
    logic [PosBits-1:0]     pos;
    logic [PosBits-1:0]     stop;
    acip_err_e              err;
  } acip_state_t;

  localparam acip_state_t StateReset = '{
    phase:      PH_LEAD,
    acc:        '0,
    digit_seen: 1'b0,
    negative:   1'b0,
    base16:     1'b0,
    pos:        '0,
    stop:       '0,
    err:        ERR_NONE
  };

  // Digit value of a character; valid flag low for anything that is no hex digit.
  function automatic logic [4:0] acip_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/acip_step.sv
module acip_step import acip_pkg::*; (
  input  acip_cfg_t   cfg_i,
  input  acip_state_t st_i,
  input  logic [7:0]  char_i,
  output acip_state_t st_o
);

  logic [4:0]           dig;
  logic                 is_b16;
  logic                 dig_ok;
  logic [ValueBits+3:0] acc_ext;
  logic [ValueBits+3:0] acc_next;
  logic                 acc_ovf;
  logic                 run;
  acip_state_t          nx;

  // One shift-add: times 16 or times 10, plus the digit, with carry-out bits kept.
  assign acc_ext = {4'b0, st_i.acc};
  assign dig     = acip_digit(char_i);
  assign is_b16  = cfg_i.hex_base | st_i.base16;
  assign dig_ok  = dig[4] & (is_b16 | (dig[3:0] < 4'd10));

  always_comb begin
    if (is_b16) begin
      acc_next = (acc_ext << 4) + {{ValueBits{1'b0}}, dig[3:0]};
    end else begin
      acc_next = (acc_ext << 3) + (acc_ext << 1) + {{ValueBits{1'b0}}, dig[3:0]};
    end
  end
  assign acc_ovf = |acc_next[ValueBits+3:ValueBits];

  // The phases only move forward in declaration order, so one ordered
  // pass over them covers every fall-through a byte can take.
  always_comb begin
    nx  = st_i;
    run = 1'b1;

    if (run && nx.phase == PH_LEAD) begin
      if (!cfg_i.keep_leading_spaces && char_i == ChSpace) run = 1'b0;
      else nx.phase = PH_SIGN;
    end
    if (run && nx.phase == PH_SIGN) begin
      nx.phase = PH_ZERO;
      if (char_i == ChMinus) begin
        run = 1'b0;
        if (cfg_i.unsigned_only) begin
          nx.err = ERR_MINUS; nx.stop = st_i.pos; nx.phase = PH_ERR;
        end else begin
          nx.negative = 1'b1;
        end
      end
    end
    if (run && nx.phase == PH_ZERO) begin
      if (char_i == ChZero) begin
        nx.digit_seen = 1'b1; run = 1'b0;
      end else begin
        nx.phase = PH_PREFIX;
      end
    end
    if (run && nx.phase == PH_PREFIX) begin
      nx.phase = PH_DIGIT;
      if (char_i == ChLowX || char_i == ChUpX) begin
        run = 1'b0;
        if (!cfg_i.allow_hex_prefix) begin
          nx.err = ERR_ILLEGAL; nx.stop = st_i.pos; nx.phase = PH_ERR;
        end else begin
          nx.digit_seen = 1'b0; nx.base16 = 1'b1;
        end
      end
    end
    if (run && nx.phase == PH_DIGIT) begin
      if (dig_ok) begin
        run = 1'b0;
        nx.digit_seen = 1'b1;
        if (acc_ovf) begin
          nx.err = ERR_OVERFLOW; nx.stop = st_i.pos; nx.phase = PH_ERR;
        end else begin
          nx.acc = acc_next[ValueBits-1:0];
        end
      end else begin
        nx.phase = PH_DOT;
      end
    end
    if (run && nx.phase == PH_DOT) begin
      nx.phase = PH_CHECK;
      if (cfg_i.allow_decimal_round && !is_b16 && char_i == ChDot) begin
        nx.phase = PH_FRAC1; run = 1'b0;
      end
    end
    if (run && nx.phase == PH_FRAC1) begin
      nx.phase = PH_FRAC;
      if (char_i >= ChFive && char_i <= ChNine) begin
        if (&st_i.acc) begin
          nx.err = ERR_OVERFLOW; nx.stop = st_i.pos; nx.phase = PH_ERR; run = 1'b0;
        end else begin
          nx.acc = st_i.acc + 1'b1;
        end
      end
    end
    if (run && nx.phase == PH_FRAC) begin
      if (char_i >= ChZero && char_i <= ChNine) run = 1'b0;
      else nx.phase = PH_CHECK;
    end
    if (run && nx.phase == PH_CHECK) begin
      nx.phase = PH_TAIL;
      if (cfg_i.require_digits && !nx.digit_seen) begin
        nx.err = ERR_NO_DIGITS; nx.stop = st_i.pos; nx.phase = PH_ERR; run = 1'b0;
      end
    end
    if (run && nx.phase == PH_TAIL) begin
      if (!cfg_i.keep_trailing_spaces && char_i == ChSpace) run = 1'b0;
      else nx.phase = PH_END;
    end
    if (run && nx.phase == PH_END) begin
      run = 1'b0;
      if (char_i == ChNul || cfg_i.allow_any_tail) begin
        nx.stop = st_i.pos; nx.phase = PH_HOLD;
      end else begin
        nx.err = ERR_ILLEGAL; nx.stop = st_i.pos; nx.phase = PH_ERR;
      end
    end

    if (char_i != ChNul && st_i.pos != PosMax) begin
      nx.pos = st_i.pos + 1'b1;
    end
    st_o = nx;
  end

endmodule

>>> hw/rtl/ascii_to_integer_parser.sv
// Streaming ASCII to integer parser.
//
// Input channel: one character per beat on char_code_i, handshaked by
// in_valid_i and in_stall_o. A zero byte ends the string. Every other byte
// produces no result; the terminating byte produces exactly one result beat.
// Output channel: parse_ok_o, error_code_o, parsed_value_o and stop_index_o,
// handshaked by out_valid_o and out_stall_i.
//
// An accepted beat lands first in the input register; from there it updates
// the parse state and, for a zero byte, the result register, which then
// offers the result. One character is taken per cycle unless a zero byte
// waits behind a stalled result; the limiting path is the 64-bit shift-add
// with carry check in acip_step.
//
// Reset clears the parse state, the eight configuration bits and both valid
// flags. When the receiver stalls, the result is held and non-zero bytes
// keep flowing; only a zero byte waiting in the input register behind a
// stalled result raises in_stall_o. Configuration writes take effect for
// the next byte processed and are meant to happen while the block is idle.
module ascii_to_integer_parser import acip_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [0:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           char_code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 parse_ok_o,
  output logic [2:0]           error_code_o,
  output logic [ValueBits-1:0] parsed_value_o,
  output logic [PosBits-1:0]   stop_index_o
);

  acip_cfg_t   cfg_q;
  acip_state_t st_q, st_d, st_step;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_blocked, s1_advance, in_accept, res_load;

  logic                 out_valid_q;
  logic                 ok_q;
  acip_err_e            err_q;
  logic [ValueBits-1:0] value_q;
  logic [PosBits-1:0]   stop_q;

  // Configuration register file, one bit per register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (acip_reg_e'(cfg_idx_i))
        REG_HEX_BASE:       cfg_q.hex_base             <= cfg_data_i[0];
        REG_ALLOW_PREFIX:   cfg_q.allow_hex_prefix     <= cfg_data_i[0];
        REG_UNSIGNED_ONLY:  cfg_q.unsigned_only        <= cfg_data_i[0];
        REG_KEEP_LEAD:      cfg_q.keep_leading_spaces  <= cfg_data_i[0];
        REG_KEEP_TRAIL:     cfg_q.keep_trailing_spaces <= cfg_data_i[0];
        REG_ANY_TAIL:       cfg_q.allow_any_tail       <= cfg_data_i[0];
        REG_REQUIRE_DIGITS: cfg_q.require_digits       <= cfg_data_i[0];
        REG_DECIMAL_ROUND:  cfg_q.allow_decimal_round  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Only a terminating byte needs the result register; it waits when the
  // result register is full and the receiver is stalling.
  assign s1_blocked = s1_valid_q && (s1_char_q == ChNul) && out_valid_q && out_stall_i;
  assign s1_advance = s1_valid_q && !s1_blocked;
  assign in_stall_o = s1_blocked;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign res_load   = s1_advance && (s1_char_q == ChNul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q <= char_code_i;
    end
  end

  acip_step u_step (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .char_i (s1_char_q),
    .st_o   (st_step)
  );

  // After a terminating byte the parse state starts over.
  always_comb begin
    st_d = st_q;
    if (s1_advance) begin
      st_d = (s1_char_q == ChNul) ? StateReset : st_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      ok_q   <= (st_step.err == ERR_NONE);
      err_q  <= st_step.err;
      stop_q <= st_step.stop;
      if (st_step.err != ERR_NONE) begin
        value_q <= '0;
      end else if (st_step.negative) begin
        value_q <= ~st_step.acc + 1'b1;
      end else begin
        value_q <= st_step.acc;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parse_ok_o     = ok_q;
  assign error_code_o   = err_q;
  assign parsed_value_o = value_q;
  assign stop_index_o   = stop_q;

endmodule

>>> hw/rtl/acip_checker.sv
module acip_checker import acip_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 parse_ok_o,
  input logic [2:0]           error_code_o,
  input logic [ValueBits-1:0] parsed_value_o,
  input logic [PosBits-1:0]   stop_index_o
);

  // A stalled result beat stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(parsed_value_o)
      && $stable(error_code_o) && $stable(stop_index_o) && $stable(parse_ok_o))
    else $error("stalled result beat changed");

  // Input only backs up behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A success carries no error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_ok_o |-> error_code_o == ERR_NONE)
    else $error("success beat with error code");

  // A failure carries a known error code and a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !parse_ok_o |-> parsed_value_o == '0
      && (error_code_o == ERR_NO_DIGITS || error_code_o == ERR_ILLEGAL
      || error_code_o == ERR_MINUS || error_code_o == ERR_OVERFLOW))
    else $error("bad failure beat");

endmodule

bind ascii_to_integer_parser acip_checker u_acip_checker (.*);

>>> bench/ascii_to_integer_parser_test.sv
`timescale 1ns / 1ps

// Checks the streaming ASCII to integer parser. Characters are sent one beat at
// a time, and a software copy of the parse machine follows every accepted beat.
// Each zero byte closes a string and queues the number that the block should
// report. A separate process takes every result beat the block offers and
// compares it with the oldest queued number, field by field.
module ascii_to_integer_parser_test;
  import acip_pkg::*;

  // The run is ended here at the latest.
  localparam int CycleLimit = 200000;
  // Cycles from a beat at the input to the end of its processing, plus margin.
  localparam int SettleCycles = 3;

  // Hex letter bounds in ASCII.
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpF  = 8'h46;

  typedef struct packed {
    logic                 ok;
    acip_err_e            err;
    logic [ValueBits-1:0] value;
    logic [PosBits-1:0]   stop;
  } number_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [2:0]           cfg_idx_i;
  logic [0:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           char_code_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 parse_ok_o;
  logic [2:0]           error_code_o;
  logic [ValueBits-1:0] parsed_value_o;
  logic [PosBits-1:0]   stop_index_o;

  ascii_to_integer_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .parse_ok_o    (parse_ok_o),
    .error_code_o  (error_code_o),
    .parsed_value_o(parsed_value_o),
    .stop_index_o  (stop_index_o)
  );

  // Register values as the block should hold them.
  acip_cfg_t            live_cfg;

  // Software copy of the parse machine.
  acip_phase_e          parse_phase;
  logic [ValueBits-1:0] parse_acc;
  logic                 parse_digit_seen;
  logic                 parse_negative;
  logic                 parse_base16;
  logic [PosBits-1:0]   parse_pos;
  logic [PosBits-1:0]   parse_stop;
  acip_err_e            parse_err;

  // Numbers that closed strings should still produce, oldest first.
  number_result_t       expected_numbers[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int chars_sent;
  int results_seen;
  int mismatches;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls at random; the percentage changes between phases.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic void clear_parse();
    parse_phase      = PH_LEAD;
    parse_acc        = '0;
    parse_digit_seen = 1'b0;
    parse_negative   = 1'b0;
    parse_base16     = 1'b0;
    parse_pos        = '0;
    parse_stop       = '0;
    parse_err        = ERR_NONE;
  endfunction

  // An error records the stop position and parks the parser until the zero byte.
  function automatic void abort_parse(input acip_err_e why);
    parse_err   = why;
    parse_stop  = parse_pos;
    parse_phase = PH_ERR;
  endfunction

  // Advances the copy of the parse machine by one character. A character may
  // fall through several phases before one of them takes it, so the phases
  // are walked in a loop until the character is consumed.
  function automatic void parse_char(input logic [7:0] c);
    logic           consumed;
    logic           b16;
    logic [4:0]     base;
    logic [4:0]     dv;
    logic [68:0]    wide;
    number_result_t res;
    consumed = 1'b0;
    while (!consumed) begin
      b16  = live_cfg.hex_base || parse_base16;
      base = b16 ? 5'd16 : 5'd10;
      case (parse_phase)
        PH_LEAD: begin
          if (!live_cfg.keep_leading_spaces && c == ChSpace) consumed = 1'b1;
          else parse_phase = PH_SIGN;
        end
        PH_SIGN: begin
          parse_phase = PH_ZERO;
          if (c == ChMinus) begin
            consumed = 1'b1;
            if (live_cfg.unsigned_only) abort_parse(ERR_MINUS);
            else parse_negative = 1'b1;
          end
        end
        PH_ZERO: begin
          if (c == ChZero) begin
            parse_digit_seen = 1'b1;
            consumed         = 1'b1;
          end else begin
            parse_phase = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          parse_phase = PH_DIGIT;
          if (c == ChLowX || c == ChUpX) begin
            consumed = 1'b1;
            if (!live_cfg.allow_hex_prefix) begin
              abort_parse(ERR_ILLEGAL);
            end else begin
              // Zeros before the prefix do not count as digits of the number.
              parse_digit_seen = 1'b0;
              parse_base16     = 1'b1;
            end
          end
        end
        PH_DIGIT: begin
          if (c >= ChZero && c <= ChNine) dv = 5'(c - ChZero);
          else if (c >= ChLowA && c <= ChLowF) dv = 5'(c - ChLowA + 8'd10);
          else if (c >= ChUpA && c <= ChUpF) dv = 5'(c - ChUpA + 8'd10);
          else dv = 5'd31;
          if (dv < base) begin
            consumed         = 1'b1;
            parse_digit_seen = 1'b1;
            // Any carry out of the value width is an overflow.
            wide = 69'(parse_acc) * 69'(base) + 69'(dv);
            if (wide[68:ValueBits] != '0) abort_parse(ERR_OVERFLOW);
            else parse_acc = wide[ValueBits-1:0];
          end else begin
            parse_phase = PH_DOT;
          end
        end
        PH_DOT: begin
          parse_phase = PH_CHECK;
          if (live_cfg.allow_decimal_round && !b16 && c == ChDot) begin
            parse_phase = PH_FRAC1;
            consumed    = 1'b1;
          end
        end
        PH_FRAC1: begin
          // The first fraction digit only rounds; it is then eaten as fraction.
          parse_phase = PH_FRAC;
          if (c >= ChFive && c <= ChNine) begin
            if (&parse_acc) begin
              abort_parse(ERR_OVERFLOW);
              consumed = 1'b1;
            end else begin
              parse_acc++;
            end
          end
        end
        PH_FRAC: begin
          if (c >= ChZero && c <= ChNine) consumed = 1'b1;
          else parse_phase = PH_CHECK;
        end
        PH_CHECK: begin
          parse_phase = PH_TAIL;
          if (live_cfg.require_digits && !parse_digit_seen) begin
            abort_parse(ERR_NO_DIGITS);
            consumed = 1'b1;
          end
        end
        PH_TAIL: begin
          if (!live_cfg.keep_trailing_spaces && c == ChSpace) consumed = 1'b1;
          else parse_phase = PH_END;
        end
        PH_END: begin
          consumed = 1'b1;
          if (c == ChNul || live_cfg.allow_any_tail) begin
            parse_stop  = parse_pos;
            parse_phase = PH_HOLD;
          end else begin
            abort_parse(ERR_ILLEGAL);
          end
        end
        default: consumed = 1'b1;
      endcase
    end

    if (c != ChNul) begin
      if (parse_pos != PosMax) parse_pos++;
    end else begin
      res.ok    = (parse_err == ERR_NONE);
      res.err   = parse_err;
      res.value = !res.ok ? '0 : (parse_negative ? (64'd0 - parse_acc) : parse_acc);
      res.stop  = parse_stop;
      expected_numbers.push_back(res);
      clear_parse();
    end
  endfunction

  // Compares every result beat that the block hands over with the oldest
  // queued number. Outputs are sampled at the edge, before the block updates.
  always @(posedge clk_i) begin : check_results
    number_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: ok %0b err %0d value %h stop %0d",
                   parse_ok_o, error_code_o, parsed_value_o, stop_index_o);
        end
      end else begin
        want = expected_numbers.pop_front();
        if (parse_ok_o !== want.ok || error_code_o !== want.err ||
            parsed_value_o !== want.value || stop_index_o !== want.stop) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d differs (expected / actual):", results_seen);
            $display("  ok %0b / %0b  err %0d / %0d  stop %0d / %0d",
                     want.ok, parse_ok_o, want.err, error_code_o,
                     want.stop, stop_index_o);
            $display("  value %h / %h", want.value, parsed_value_o);
          end
        end
      end
    end
  end

  // Sends one character beat, with random idle cycles in front of it, and
  // hands it to the parse copy once the block has taken it. Returns at the
  // edge that accepted the beat, with valid still high.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(ChNul);
  endtask

  // Drops valid and holds the input side quiet until every number is back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input acip_reg_e idx, input logic value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Register writes only happen with no string in flight: all numbers are
  // back, and a settling wait lets the last beats work through the block.
  task automatic apply_config(input acip_cfg_t c);
    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(REG_HEX_BASE,       c.hex_base);
    write_reg(REG_ALLOW_PREFIX,   c.allow_hex_prefix);
    write_reg(REG_UNSIGNED_ONLY,  c.unsigned_only);
    write_reg(REG_KEEP_LEAD,      c.keep_leading_spaces);
    write_reg(REG_KEEP_TRAIL,     c.keep_trailing_spaces);
    write_reg(REG_ANY_TAIL,       c.allow_any_tail);
    write_reg(REG_REQUIRE_DIGITS, c.require_digits);
    write_reg(REG_DECIMAL_ROUND,  c.allow_decimal_round);
    cfg_we_i <= 1'b0;
    live_cfg = c;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return 8'(ChZero + v);
    return 8'(v - 10) + ($urandom_range(1) ? ChLowA : ChUpA);
  endfunction

  // Most strings are well formed numbers with random content, so that the
  // deeper phases (prefix, long digit runs, rounding, tail) see real traffic.
  // The rest are raw byte noise or numbers with a stray byte thrown in.
  task automatic send_random_string();
    logic [7:0] text[$];
    logic       hexy;
    string      near_max;
    near_max = "1844674407370955161";
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(12)) text.push_back(8'($urandom_range(255, 1)));
    end else begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) text.push_back(ChSpace);
      if ($urandom_range(3) == 0) text.push_back(ChMinus);
      if ($urandom_range(2) == 0) repeat ($urandom_range(3, 1)) text.push_back(ChZero);
      hexy = live_cfg.hex_base;
      if ($urandom_range(4) == 0) begin
        text.push_back($urandom_range(1) ? ChLowX : ChUpX);
        hexy = 1'b1;
      end
      case ($urandom_range(9))
        0: begin
          // Right at the top of the value range, sometimes one digit past it.
          if (hexy) begin
            repeat (16) text.push_back(digit_char(15));
            if ($urandom_range(1)) text.push_back(digit_char($urandom_range(15)));
          end else begin
            for (int i = 0; i < near_max.len(); i++) text.push_back(near_max[i]);
            text.push_back(digit_char($urandom_range(9, 4)));
            if ($urandom_range(3) == 0) text.push_back(digit_char($urandom_range(9)));
          end
        end
        1: repeat ($urandom_range(22, 15))
             text.push_back(digit_char(hexy ? $urandom_range(15) : $urandom_range(9)));
        default: repeat ($urandom_range(6))
             text.push_back(digit_char(hexy ? $urandom_range(15) : $urandom_range(9)));
      endcase
      if ($urandom_range(3) == 0) begin
        text.push_back(ChDot);
        repeat ($urandom_range(3)) text.push_back(digit_char($urandom_range(9)));
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) text.push_back(ChSpace);
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(2, 1)) text.push_back(8'($urandom_range(126, 33)));
      end
      if ($urandom_range(9) == 0) begin
        text.insert($urandom_range(text.size()), 8'($urandom_range(255, 1)));
      end
    end
    foreach (text[i]) send_char(text[i]);
    send_char(ChNul);
  endtask

  // Reset register values: plain decimal with skipping of spaces on both sides.
  task automatic test_default_parsing();
    send_text("123");
    send_text("   -42  ");
    send_text("");
    send_text("12a");
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    send_text("0x1F");
    send_text("007");
    send_text("-");
    send_text("1 2");
    send_text("12.5");
  endtask

  // Minus forbidden, digits required, hex prefix and decimal rounding allowed.
  task automatic test_strict_rounding();
    acip_cfg_t c;
    c = '0;
    c.unsigned_only       = 1'b1;
    c.require_digits      = 1'b1;
    c.allow_hex_prefix    = 1'b1;
    c.allow_decimal_round = 1'b1;
    apply_config(c);
    send_text("-5");
    send_text("");
    send_text("0x");
    send_text("0xffffffffffffffff");
    send_text("x10");
    send_text("12.5");
    send_text("12.49");
    send_text("18446744073709551615.7");
    send_text("7.");
  endtask

  // Hex digits, spaces kept on both sides, any tail, and a dot that must not
  // be taken as a decimal point in base 16.
  task automatic test_hex_relaxed();
    acip_cfg_t c;
    c = '0;
    c.hex_base             = 1'b1;
    c.keep_leading_spaces  = 1'b1;
    c.keep_trailing_spaces = 1'b1;
    c.allow_any_tail       = 1'b1;
    c.allow_decimal_round  = 1'b1;
    apply_config(c);
    send_text(" 1");
    send_text("ABCdef");
    send_text("1.5");
    send_text("10000000000000000");
    send_text("12 zz");
  endtask

  // A string longer than the position counter: the stop index saturates.
  task automatic test_position_saturation();
    apply_config('0);
    repeat (256) send_char(ChSpace);
    send_char(ChFive);
    send_char(ChNul);
  endtask

  // Random strings under one idling pattern, across three register settings.
  // Now and then the sender waits for all numbers to come back first.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input acip_cfg_t first_cfg, input int n_chars);
    int stop_at;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int seg = 0; seg < 3; seg++) begin
      apply_config(seg == 0 ? first_cfg : acip_cfg_t'(8'($urandom_range(255))));
      stop_at = chars_sent + n_chars / 3;
      while (chars_sent < stop_at) begin
        send_random_string();
        if ($urandom_range(9) == 0) wait_results_drained();
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    char_code_i        <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_HEX_BASE;
    cfg_data_i         <= '0;
    out_stall_i        <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    live_cfg           = '0;
    clear_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_parsing();
    test_strict_rounding();
    test_hex_relaxed();
    test_position_saturation();

    // Idling phases; the first two start from the all-clear and all-set registers.
    test_random_traffic(0, 0, '0, 48);
    test_random_traffic(48, 0, '1, 48);
    test_random_traffic(0, 48, acip_cfg_t'(8'($urandom_range(255))), 48);
    test_random_traffic(38, 38, acip_cfg_t'(8'($urandom_range(255))), 48);

    wait_results_drained();
    repeat (SettleCycles + 1) @(posedge clk_i);
    if (mismatches == 0 && expected_numbers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/acip_pkg.sv
hw/rtl/acip_step.sv
hw/rtl/ascii_to_integer_parser.sv
hw/rtl/acip_checker.sv
bench/ascii_to_integer_parser_test.sv
